@@ rtl/zx0sd_pkg.sv @@
// shared types and constants of the zx0 stream decompressor
// used by the controller, the datapath and the top level
package zx0sd_pkg;

    localparam int COUNT_W    = 24;
    localparam int GAMMA_W    = COUNT_W + 1;
    localparam int LEN_W      = COUNT_W + 2;
    localparam int HIST_DEPTH = 32768;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int OFF_W      = HIST_AW + 1;
    localparam int OUT_W      = 40;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_OFFSET  = 3'd1,
        ERR_LIMIT   = 3'd2,
        ERR_GAMMA   = 3'd3,
        ERR_TRUNC   = 3'd4,
        ERR_COUNT   = 3'd5,
        ERR_REFUSED = 3'd6
    } err_t;

    typedef enum logic [9:0] {
        PH_LITLEN    = 10'b00_0000_0001,
        PH_LIT       = 10'b00_0000_0010,
        PH_SEL_LIT   = 10'b00_0000_0100,
        PH_REPLEN    = 10'b00_0000_1000,
        PH_COPY      = 10'b00_0001_0000,
        PH_SEL_MATCH = 10'b00_0010_0000,
        PH_OFFMSB    = 10'b00_0100_0000,
        PH_OFFLSB    = 10'b00_1000_0000,
        PH_NEWLEN    = 10'b01_0000_0000,
        PH_DONE      = 10'b10_0000_0000
    } phase_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_START = 5'b00010,
        ST_COPY  = 5'b00100,
        ST_BITS  = 5'b01000,
        ST_FIN   = 5'b10000
    } state_t;

    typedef struct packed {
        logic accept;
        logic start;
        logic copy;
        logic bit_step;
        logic close;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic ok;
        logic pull;
        logic bit_more;
        logic out_free;
    } dp_stat_t;

endpackage

@@ rtl/zx0sd_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module zx0sd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/zx0sd_ctrl.sv @@
// sequencing state machine of the zx0 stream decompressor
// depends on zx0sd_pkg
module zx0sd_ctrl import zx0sd_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.start = 1'b1;
                if (!stat.ok) begin
                    state_next = ST_FIN;
                end else if (stat.pull) begin
                    state_next = ST_COPY;
                end else begin
                    state_next = ST_BITS;
                end
            end
            ST_COPY: begin
                cmd.copy   = 1'b1;
                state_next = ST_BITS;
            end
            ST_BITS: begin
                if (stat.bit_more) begin
                    cmd.bit_step = 1'b1;
                end else begin
                    cmd.close  = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

@@ rtl/zx0sd_dp.sv @@
// datapath of the zx0 stream decompressor: parse state, gamma decoding,
// history ram and the result register; depends on zx0sd_pkg and zx0sd_ram
module zx0sd_dp import zx0sd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata,
    input  logic               in_cmd,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    input  logic               m_tready,
    output logic               m_tvalid,
    output logic [OUT_W-1:0]   m_tdata,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat
);

    logic [COUNT_W-1:0] limit_reg, limit_next;
    logic [COUNT_W-1:0] produced_reg, produced_next;
    logic [7:0]         buf_reg, buf_next;
    logic [7:0]         mask_reg, mask_next;
    logic [7:0]         prev_reg, prev_next;
    logic               reuse_reg, reuse_next;
    logic [OFF_W-1:0]   offset_reg, offset_next;
    phase_t             phase_reg, phase_next;
    logic [GAMMA_W-1:0] acc_reg, acc_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic [8:0]         offhi_reg, offhi_next;
    err_t               sticky_reg, sticky_next;
    logic               gdn_reg, gdn_next;
    logic               closed_reg, closed_next;
    logic               icmd_reg, icmd_next;
    logic [7:0]         ibyte_reg, ibyte_next;
    logic               ilast_reg, ilast_next;
    err_t               code_reg, code_next;
    logic               ov_reg, ov_next;
    logic [7:0]         ob_reg, ob_next;
    logic               mv_reg, mv_next;
    logic [OUT_W-1:0]   md_reg, md_next;

    logic [COUNT_W-1:0] room;
    logic               wants, bit_phase, bit_avail, bit_val, ok;
    logic               ram_we;
    logic [7:0]         ram_wdata, ram_rdata;
    logic [HIST_AW-1:0] ram_raddr;
    logic [16:0]        new_off;
    logic [LEN_W-1:0]   len;
    logic               off_too_far;

    zx0sd_ram #(.WIDTH(8), .DEPTH(HIST_DEPTH)) u_hist (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (produced_reg[HIST_AW-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_raddr = produced_reg[HIST_AW-1:0] - offset_reg[HIST_AW-1:0];
    assign room      = (limit_reg > produced_reg) ? (limit_reg - produced_reg) : '0;
    assign wants     = (sticky_reg == ERR_NONE) && (phase_reg != PH_COPY)
                       && (phase_reg != PH_DONE);
    assign bit_phase = (phase_reg == PH_LITLEN) || (phase_reg == PH_SEL_LIT)
                       || (phase_reg == PH_REPLEN) || (phase_reg == PH_SEL_MATCH)
                       || (phase_reg == PH_OFFMSB) || (phase_reg == PH_NEWLEN);
    assign bit_avail = reuse_reg || (mask_reg != 8'd0);
    assign bit_val   = reuse_reg ? prev_reg[0] : |(buf_reg & mask_reg);
    assign ok        = (sticky_reg == ERR_NONE) && (phase_reg != PH_DONE)
                       && ((icmd_reg == CMD_PUSH) ? (wants && !closed_reg)
                                                  : (phase_reg == PH_COPY));
    assign new_off   = 17'({offhi_reg, 7'd0}) - 17'(ibyte_reg[7:1]);
    assign len       = (phase_reg == PH_NEWLEN) ? (LEN_W'(acc_reg) + LEN_W'(1))
                                                : LEN_W'(acc_reg);
    assign off_too_far = COUNT_W'(offset_reg) > produced_reg;

    assign ram_we    = (cmd.start && ok && (icmd_reg == CMD_PUSH) && (phase_reg == PH_LIT))
                       || cmd.copy;
    assign ram_wdata = cmd.copy ? ram_rdata : ibyte_reg;

    assign stat.ok       = ok;
    assign stat.pull     = (icmd_reg == CMD_PULL);
    assign stat.bit_more = (sticky_reg == ERR_NONE) && bit_phase && bit_avail;
    assign stat.out_free = !mv_reg || m_tready;

    always_comb begin
        limit_next    = limit_reg;
        produced_next = produced_reg;
        buf_next      = buf_reg;
        mask_next     = mask_reg;
        prev_next     = prev_reg;
        reuse_next    = reuse_reg;
        offset_next   = offset_reg;
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        offhi_next    = offhi_reg;
        sticky_next   = sticky_reg;
        gdn_next      = gdn_reg;
        closed_next   = closed_reg;
        icmd_next     = icmd_reg;
        ibyte_next    = ibyte_reg;
        ilast_next    = ilast_reg;
        code_next     = code_reg;
        ov_next       = ov_reg;
        ob_next       = ob_reg;
        mv_next       = mv_reg;
        md_next       = md_reg;

        if (cfg_we) begin
            limit_next = cfg_wdata;
        end

        if (cmd.accept) begin
            icmd_next  = in_cmd;
            ibyte_next = in_byte;
            ilast_next = in_last;
        end

        if (cmd.start) begin
            ov_next = 1'b0;
            ob_next = 8'd0;
            if (!ok) begin
                code_next = (sticky_reg != ERR_NONE) ? sticky_reg : ERR_REFUSED;
            end else if (icmd_reg == CMD_PUSH) begin
                if (ilast_reg) begin
                    closed_next = 1'b1;
                end
                if (phase_reg == PH_LIT) begin
                    ov_next       = 1'b1;
                    ob_next       = ibyte_reg;
                    produced_next = produced_reg + COUNT_W'(1);
                    rem_next      = rem_reg - COUNT_W'(1);
                    if (rem_reg == COUNT_W'(1)) begin
                        phase_next = PH_SEL_LIT;
                    end
                end else if (phase_reg == PH_OFFLSB) begin
                    prev_next  = ibyte_reg;
                    reuse_next = 1'b1;
                    if ((new_off == 17'd0) || (new_off > 17'(HIST_DEPTH))) begin
                        sticky_next = ERR_OFFSET;
                    end else begin
                        offset_next = OFF_W'(new_off);
                        phase_next  = PH_NEWLEN;
                    end
                end else begin
                    buf_next  = ibyte_reg;
                    mask_next = 8'h80;
                end
            end
        end

        if (cmd.copy) begin
            ov_next       = 1'b1;
            ob_next       = ram_rdata;
            produced_next = produced_reg + COUNT_W'(1);
            rem_next      = rem_reg - COUNT_W'(1);
            if (rem_reg == COUNT_W'(1)) begin
                phase_next = PH_SEL_MATCH;
            end
        end

        if (cmd.bit_step) begin
            if (reuse_reg) begin
                reuse_next = 1'b0;
            end else begin
                mask_next = mask_reg >> 1;
            end
            if (phase_reg == PH_SEL_LIT) begin
                phase_next = bit_val ? PH_OFFMSB : PH_REPLEN;
            end else if (phase_reg == PH_SEL_MATCH) begin
                phase_next = bit_val ? PH_OFFMSB : PH_LITLEN;
            end else if (gdn_reg) begin
                acc_next = {acc_reg[GAMMA_W-2:0], bit_val ^ (phase_reg == PH_OFFMSB)};
                gdn_next = 1'b0;
            end else if (!bit_val) begin
                if (acc_reg[GAMMA_W-1]) begin
                    sticky_next = ERR_GAMMA;
                end else begin
                    gdn_next = 1'b1;
                end
            end else begin
                acc_next = GAMMA_W'(1);
                if (phase_reg == PH_LITLEN) begin
                    if (len > LEN_W'(room)) begin
                        sticky_next = ERR_LIMIT;
                    end else begin
                        rem_next   = COUNT_W'(len);
                        phase_next = PH_LIT;
                    end
                end else if (phase_reg == PH_OFFMSB) begin
                    if (acc_reg == GAMMA_W'(256)) begin
                        if (produced_reg == limit_reg) begin
                            phase_next = PH_DONE;
                        end else begin
                            sticky_next = ERR_COUNT;
                        end
                    end else if (acc_reg > GAMMA_W'(511)) begin
                        sticky_next = ERR_OFFSET;
                    end else begin
                        offhi_next = acc_reg[8:0];
                        phase_next = PH_OFFLSB;
                    end
                end else begin
                    if (off_too_far) begin
                        sticky_next = ERR_OFFSET;
                    end else if (len > LEN_W'(room)) begin
                        sticky_next = ERR_LIMIT;
                    end else begin
                        rem_next   = COUNT_W'(len);
                        phase_next = PH_COPY;
                    end
                end
            end
        end

        if (cmd.close) begin
            if (wants && closed_reg) begin
                sticky_next = ERR_TRUNC;
                code_next   = ERR_TRUNC;
            end else begin
                code_next = sticky_reg;
            end
        end

        if (cmd.emit) begin
            mv_next = 1'b1;
            md_next = OUT_W'({produced_reg, code_reg,
                              (sticky_reg == ERR_NONE) && (phase_reg == PH_DONE),
                              wants && !closed_reg, ob_reg, ov_reg});
        end else if (m_tready) begin
            mv_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg    <= '0;
            produced_reg <= '0;
            buf_reg      <= '0;
            mask_reg     <= '0;
            prev_reg     <= '0;
            reuse_reg    <= 1'b0;
            offset_reg   <= OFF_W'(1);
            phase_reg    <= PH_LITLEN;
            acc_reg      <= GAMMA_W'(1);
            rem_reg      <= '0;
            offhi_reg    <= '0;
            sticky_reg   <= ERR_NONE;
            gdn_reg      <= 1'b0;
            closed_reg   <= 1'b0;
            code_reg     <= ERR_NONE;
            mv_reg       <= 1'b0;
        end else begin
            limit_reg    <= limit_next;
            produced_reg <= produced_next;
            buf_reg      <= buf_next;
            mask_reg     <= mask_next;
            prev_reg     <= prev_next;
            reuse_reg    <= reuse_next;
            offset_reg   <= offset_next;
            phase_reg    <= phase_next;
            acc_reg      <= acc_next;
            rem_reg      <= rem_next;
            offhi_reg    <= offhi_next;
            sticky_reg   <= sticky_next;
            gdn_reg      <= gdn_next;
            closed_reg   <= closed_next;
            code_reg     <= code_next;
            mv_reg       <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        icmd_reg  <= icmd_next;
        ibyte_reg <= ibyte_next;
        ilast_reg <= ilast_next;
        ov_reg    <= ov_next;
        ob_reg    <= ob_next;
        md_reg    <= md_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

endmodule

@@ rtl/zx0_stream_decompressor.sv @@
// top level of the zx0 stream decompressor
// depends on zx0sd_pkg, zx0sd_ctrl and zx0sd_dp
//
// usage: each transaction on the s_ channel is one command, push (tuser 0,
// compressed byte in tdata, tlast on the final byte) or pull (tuser 1).
// every command gives exactly one transaction on the m_ channel carrying
// the decoded byte if any, need_byte, finished, the error code and the
// running output count. cfg_we writes the expected output length.
// a refused command goes from acceptance through the start state straight to
// its result transaction; any other command passes the start state, the
// history ram read and copy on a pull, one bit step per control bit parsed
// (at most 8 for one command) and a closing step; the gamma parser is single-bit.
// s_tready is high only between commands, and one command is in flight at a
// time.
// the result sits in an output register; the next command is accepted
// while it waits, and that command stalls before its own result until the
// receiver takes the earlier one.
// reset (aresetn low, synchronous) clears the parser, the count and the
// limit; the history ram is not cleared and needs no clearing pass.
module zx0_stream_decompressor import zx0sd_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,  // in_byte
    input  logic               s_tuser,  // command
    input  logic               s_tlast,  // last_input
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata   // out_valid, out_byte, need_byte, finished,
                                         // error_code, produced_count, zero pad
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    zx0sd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    zx0sd_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_cmd    (s_tuser),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.accept, cmd.start, cmd.copy, cmd.bit_step, cmd.close, cmd.emit}))
        else $error("more than one datapath command");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction accepted while busy");

    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("result overwrote a pending transaction");

    a_copy_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.copy |-> $past(cmd.start))
        else $error("history copy without preceding read");

endmodule
